// ===== hw/rtl/vdg_pkg.sv =====
// vdg_pkg: shared constants and helpers for the volume divergence block
// no dependencies
`timescale 1ns / 1ps

package vdg_pkg;

    // default limits of the volume
    localparam int unsigned DEF_MAX_SIZE_X = 128;
    localparam int unsigned DEF_MAX_SIZE_Y = 128;
    localparam int unsigned DEF_MAX_SIZE_Z = 1024;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    // field widths fixed by the interface
    localparam int unsigned DIV_BITS = 20;
    localparam int unsigned IDX_BITS = 24;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 11;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // cycles the derived sizes need after a register write
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    // job queue depth
    localparam int unsigned Q_DEPTH = 4;

    // clamp a size register to [1, mx]
    function automatic logic [12:0] clamp_size(logic [10:0] v, logic [12:0] mx);
        logic [12:0] w;
        w = {2'b00, v};
        if (v == 11'd0) return 13'd1;
        if (w > mx) return mx;
        return w;
    endfunction

    // {plus neighbour valid, minus neighbour valid, interior} for position p of n
    function automatic logic [2:0] border_flags(logic [12:0] p, logic [12:0] n);
        logic f_in, f_lo, f_hi;
        f_in = (p != 13'd0) && ((p + 13'd1) < n);
        f_lo = (p >= 13'd2);
        f_hi = ((p + 13'd2) < n);
        return {f_hi, f_lo, f_in};
    endfunction

endpackage

// ===== hw/rtl/vdg_ram.sv =====
// vdg_ram: generic single write, single read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module vdg_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/vdg_queue.sv =====
// vdg_queue: small register fifo between front and back
// depends on vdg_pkg for the depth
`timescale 1ns / 1ps

module vdg_queue import vdg_pkg::*; #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PW = $clog2(Q_DEPTH);

    logic [WIDTH-1:0] r_slot [0:Q_DEPTH-1];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [PW:0]      r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (w_pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/vdg_front.sv =====
// vdg_front: size registers, ring write, emission decision and job issue
// depends on vdg_pkg
`timescale 1ns / 1ps

module vdg_front import vdg_pkg::*; #(
    parameter int unsigned MAX_SIZE_X  = DEF_MAX_SIZE_X,
    parameter int unsigned MAX_SIZE_Y  = DEF_MAX_SIZE_Y,
    parameter int unsigned MAX_SIZE_Z  = DEF_MAX_SIZE_Z,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int unsigned RING = 5 * MAX_SIZE_X * MAX_SIZE_Y,
    localparam int unsigned AW   = $clog2(RING),
    localparam int unsigned JW   = IDX_BITS + 1 + 9 + AW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_req_type,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  logic                     i_q_full,
    output logic                     o_push,
    output logic [JW-1:0]            o_job,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [SAMPLE_BITS-1:0]   o_wr_data,
    output logic [AW-1:0]            o_stride_y,
    output logic [AW-1:0]            o_stride_z
);

    localparam int unsigned VOLMAX = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
    localparam int unsigned CW  = $clog2(RING + VOLMAX + 1);
    localparam int unsigned XW  = $clog2(MAX_SIZE_X + 1);
    localparam int unsigned YW  = $clog2(MAX_SIZE_Y + 1);
    localparam int unsigned ZW  = $clog2(MAX_SIZE_Z + 1);
    localparam int unsigned PLW = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);

    logic [7:0]   r_size_x, r_size_y;
    logic [10:0]  r_size_z;
    logic [1:0]   r_hold;
    logic [XW-1:0] w_sx;
    logic [YW-1:0] w_sy;
    logic [ZW-1:0] w_sz;
    logic [XW+YW-1:0] w_plane;
    logic [PLW-1:0]   r_plane;
    logic [PLW+ZW-1:0] w_vol;
    logic [CW-1:0]    r_vol_m1;
    logic [AW-1:0]    r_two_plane;

    logic [CW-1:0] r_pend, n_pend;
    logic [CW-1:0] r_k;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic [AW-1:0] r_wp, n_wp;
    logic [CW-1:0] w_diff;
    logic [AW-1:0] w_center;
    logic          w_accept, w_store, w_fire, w_cfg_hit, w_last;
    logic [2:0]    w_fx, w_fy, w_fz;

    assign w_sx = XW'(clamp_size({3'b000, r_size_x}, 13'(MAX_SIZE_X)));
    assign w_sy = YW'(clamp_size({3'b000, r_size_y}, 13'(MAX_SIZE_Y)));
    assign w_sz = ZW'(clamp_size(r_size_z, 13'(MAX_SIZE_Z)));
    assign w_plane = w_sx * w_sy;
    assign w_vol   = r_plane * w_sz;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_hit = i_cfg_valid && (i_cfg_index == REG_SIZE_X ||
                       i_cfg_index == REG_SIZE_Y || i_cfg_index == REG_SIZE_Z);

    assign o_ready  = (r_hold == 2'd0) && !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_store  = w_accept && (i_req_type == REQ_SAMPLE);

    always_comb begin
        n_wp   = r_wp;
        n_pend = r_pend;
        if (w_store) begin
            n_wp = (r_wp == AW'(RING - 1)) ? '0 : r_wp + AW'(1);
            if (r_pend < CW'(RING)) n_pend = r_pend + CW'(1);
        end
    end

    // ready once the look-ahead (two planes, or the volume end) is in
    assign w_fire = w_accept && ((n_pend > CW'(r_two_plane)) ||
                                 (n_pend > (r_vol_m1 - r_k)));
    assign w_last = (r_k == r_vol_m1);

    assign w_diff   = CW'(n_wp) - n_pend;
    assign w_center = (CW'(n_wp) >= n_pend) ? AW'(w_diff) : AW'(w_diff + CW'(RING));

    assign w_fx = border_flags(13'(r_x), 13'(w_sx));
    assign w_fy = border_flags(13'(r_y), 13'(w_sy));
    assign w_fz = border_flags(13'(r_z), 13'(w_sz));

    assign o_push    = w_fire;
    assign o_job     = {IDX_BITS'(r_k), w_last, w_fz, w_fy, w_fx, w_center};
    assign o_wr_en   = w_store;
    assign o_wr_addr = r_wp;
    assign o_wr_data = i_sample;
    assign o_stride_y = AW'({w_sx, 1'b0});
    assign o_stride_z = r_two_plane;

    always_ff @(posedge i_clk) begin
        r_plane     <= PLW'(w_plane);
        r_vol_m1    <= CW'(w_vol) - CW'(1);
        r_two_plane <= AW'({r_plane, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 8'd128;
            r_size_y <= 8'd128;
            r_size_z <= 11'd1024;
            r_hold   <= CFG_SETTLE;
            r_pend   <= '0;
            r_k      <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
            r_wp     <= '0;
        end else begin
            r_wp <= n_wp;
            if (r_hold != 2'd0) r_hold <= r_hold - 2'd1;
            if (w_cfg_hit) begin
                unique case (i_cfg_index)
                    REG_SIZE_X: r_size_x <= i_cfg_data[7:0];
                    REG_SIZE_Y: r_size_y <= i_cfg_data[7:0];
                    REG_SIZE_Z: r_size_z <= i_cfg_data;
                    default:    r_size_z <= r_size_z;
                endcase
                r_hold <= CFG_SETTLE;
                r_pend <= '0;
                r_k    <= '0;
                r_x    <= '0;
                r_y    <= '0;
                r_z    <= '0;
            end else if (w_fire) begin
                r_pend <= n_pend - CW'(1);
                if (w_last) begin
                    r_k <= '0;
                    r_x <= '0;
                    r_y <= '0;
                    r_z <= '0;
                end else begin
                    r_k <= r_k + CW'(1);
                    if ((r_x + XW'(1)) == w_sx) begin
                        r_x <= '0;
                        if ((r_y + YW'(1)) == w_sy) begin
                            r_y <= '0;
                            r_z <= r_z + ZW'(1);
                        end else begin
                            r_y <= r_y + YW'(1);
                        end
                    end else begin
                        r_x <= r_x + XW'(1);
                    end
                end
            end else begin
                r_pend <= n_pend;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CW'(RING)) else $error("pending count beyond ring size");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full) else $error("job issued into a full queue");
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> !o_ready) else $error("input taken before sizes settled");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold == 2'd0) |-> (r_k <= r_vol_m1)) else $error("voxel index past volume");
`endif

endmodule

// ===== hw/rtl/vdg_back.sv =====
// vdg_back: seven banked ring reads, axis terms, sum and output register
// depends on vdg_pkg and vdg_ram
`timescale 1ns / 1ps

module vdg_back import vdg_pkg::*; #(
    parameter int unsigned MAX_SIZE_X  = DEF_MAX_SIZE_X,
    parameter int unsigned MAX_SIZE_Y  = DEF_MAX_SIZE_Y,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int unsigned RING = 5 * MAX_SIZE_X * MAX_SIZE_Y,
    localparam int unsigned AW   = $clog2(RING),
    localparam int unsigned JW   = IDX_BITS + 1 + 9 + AW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  logic [JW-1:0]          i_job,
    output logic                   o_pop,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [SAMPLE_BITS-1:0] i_wr_data,
    input  logic [AW-1:0]          i_stride_y,
    input  logic [AW-1:0]          i_stride_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DIV_BITS-1:0]    o_divergence,
    output logic [IDX_BITS-1:0]    o_index,
    output logic                   o_last
);

    localparam int unsigned MW = IDX_BITS + 1 + 9;
    localparam int unsigned SW = (SAMPLE_BITS + 4 > 21) ? SAMPLE_BITS + 4 : 21;
    localparam int unsigned TW = SAMPLE_BITS + 2;

    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] c, logic [AW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, c} + {1'b0, d};
        return (s >= (AW+1)'(RING)) ? AW'(s - (AW+1)'(RING)) : AW'(s);
    endfunction

    function automatic logic [AW-1:0] ring_sub(logic [AW-1:0] c, logic [AW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, c} + (AW+1)'(RING) - {1'b0, d};
        return (c >= d) ? (c - d) : AW'(s);
    endfunction

    function automatic logic signed [TW-1:0] axis_term(
        logic signed [SAMPLE_BITS-1:0] fm, logic signed [SAMPLE_BITS-1:0] f0,
        logic signed [SAMPLE_BITS-1:0] fp, logic [2:0] fl);
        logic signed [SAMPLE_BITS:0] lo, hi;
        lo = fl[1] ? ($signed({fm[SAMPLE_BITS-1], fm}) - $signed({f0[SAMPLE_BITS-1], f0}))
                   : '0;
        hi = fl[2] ? ($signed({f0[SAMPLE_BITS-1], f0}) - $signed({fp[SAMPLE_BITS-1], fp}))
                   : '0;
        return fl[0] ? ($signed({lo[SAMPLE_BITS], lo}) - $signed({hi[SAMPLE_BITS], hi}))
                     : '0;
    endfunction

    logic          w_en;
    logic [AW-1:0] w_center;
    logic [AW-1:0] w_addr [0:6];
    logic [AW-1:0] r1_addr [0:6];
    logic [SAMPLE_BITS-1:0] w_data [0:6];
    logic          r1_valid, r2_valid, r_o_valid;
    logic [MW-1:0] r1_meta, r2_meta;
    logic [8:0]    w_flags;
    logic signed [TW-1:0] w_tx, w_ty, w_tz;
    logic signed [SW-1:0] w_sum;
    logic [DIV_BITS-1:0]  w_div;
    logic [DIV_BITS-1:0]  r_div;
    logic [IDX_BITS-1:0]  r_index;
    logic                 r_last;

    assign w_en  = !r_o_valid || i_ready;
    assign o_pop = w_en && i_job_valid;
    assign w_center = i_job[AW-1:0];

    // bank order: centre, x-2, x+2, y-2, y+2, z-2, z+2
    assign w_addr[0] = w_center;
    assign w_addr[1] = ring_sub(w_center, AW'(2));
    assign w_addr[2] = ring_add(w_center, AW'(2));
    assign w_addr[3] = ring_sub(w_center, i_stride_y);
    assign w_addr[4] = ring_add(w_center, i_stride_y);
    assign w_addr[5] = ring_sub(w_center, i_stride_z);
    assign w_addr[6] = ring_add(w_center, i_stride_z);

    for (genvar b = 0; b < 7; b++) begin : g_bank
        vdg_ram #(
            .WIDTH(SAMPLE_BITS),
            .DEPTH(RING)
        ) u_ram (
            .i_clk    (i_clk),
            .i_wr_en  (i_wr_en),
            .i_wr_addr(i_wr_addr),
            .i_wr_data(i_wr_data),
            .i_rd_en  (w_en),
            .i_rd_addr(r1_addr[b]),
            .o_rd_data(w_data[b])
        );
    end

    assign w_flags = r2_meta[8:0];
    assign w_tx = axis_term(w_data[1], w_data[0], w_data[2], w_flags[2:0]);
    assign w_ty = axis_term(w_data[3], w_data[0], w_data[4], w_flags[5:3]);
    assign w_tz = axis_term(w_data[5], w_data[0], w_data[6], w_flags[8:6]);
    assign w_sum = SW'(w_tx) + SW'(w_ty) + SW'(w_tz);

    always_comb begin
        if (w_sum > SW'(524287)) begin
            w_div = DIV_BITS'(524287);
        end else if (w_sum < -SW'(524288)) begin
            w_div = DIV_BITS'(524288);
        end else begin
            w_div = DIV_BITS'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 7; b++) begin
                r1_addr[b] <= w_addr[b];
            end
            r1_meta <= i_job[JW-1:AW];
            r2_meta <= r1_meta;
            r_div   <= w_div;
            r_index <= r2_meta[MW-1:10];
            r_last  <= r2_meta[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid  <= i_job_valid;
            r2_valid  <= r1_valid;
            r_o_valid <= r2_valid;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_divergence = r_div;
    assign o_index      = r_index;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/volume_divergence_of_gradient.sv =====
// volume_divergence_of_gradient: top level of the 3d laplacian stream block
// depends on vdg_pkg, vdg_front, vdg_queue, vdg_back and vdg_ram
`timescale 1ns / 1ps

// Signed voxels stream in raster order (x fastest) and are written into a
// ring of five planes; each output is the sum over x, y and z of the second
// central difference g(c-1) - g(c+1), g(u) = f(u-1) - f(u+1), with a zero
// term on each border, saturated to 20 bits. A voxel leaves once two planes
// of look-ahead (or the end of its volume) have arrived; flush items push
// out the tail, and volumes follow back to back. The block takes one item
// per cycle unless the queue is full or sizes settle: the ring is held in
// seven identical banks, one read each per voxel, so the seven neighbours
// come out of memory together. A result passes the four entry job queue
// and the bank address, bank read and output registers, waiting while the
// output stalls. After reset and any size register write, the input holds
// off while the plane and volume sizes settle. A register write restarts
// the voxel count; the user must write only while idle (not enforced).
module volume_divergence_of_gradient import vdg_pkg::*; #(
    parameter int unsigned MAX_SIZE_X  = DEF_MAX_SIZE_X,
    parameter int unsigned MAX_SIZE_Y  = DEF_MAX_SIZE_Y,
    parameter int unsigned MAX_SIZE_Z  = DEF_MAX_SIZE_Z,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int unsigned IN_BYTES   = (SAMPLE_BITS + 7) / 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input stream
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_BYTES*8-1:0]    i_s_tdata,   // sample
    input  logic                     i_s_tuser,   // req_type
    // result stream
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [47:0]              o_m_tdata,   // divergence, voxel_index
    output logic                     o_m_tlast    // volume_end
);

    localparam int unsigned RING = 5 * MAX_SIZE_X * MAX_SIZE_Y;
    localparam int unsigned AW   = $clog2(RING);
    localparam int unsigned JW   = IDX_BITS + 1 + 9 + AW;

    // front to queue
    logic          w_push, w_q_full;
    logic [JW-1:0] w_job_in;
    // queue to back
    logic          w_job_valid, w_pop;
    logic [JW-1:0] w_job_out;
    // ring write port and strides
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [SAMPLE_BITS-1:0] w_wr_data;
    logic [AW-1:0]          w_stride_y, w_stride_z;
    // result fields
    logic [DIV_BITS-1:0]    w_div;
    logic [IDX_BITS-1:0]    w_index;

    // accepts transfers, keeps sizes, decides when a voxel is complete
    vdg_front #(
        .MAX_SIZE_X (MAX_SIZE_X),
        .MAX_SIZE_Y (MAX_SIZE_Y),
        .MAX_SIZE_Z (MAX_SIZE_Z),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_req_type (i_s_tuser),
        .i_sample   (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_stride_y (w_stride_y),
        .o_stride_z (w_stride_z)
    );

    // lets the back stall on the output while the input goes on until the queue fills
    vdg_queue #(
        .WIDTH(JW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_job_in),
        .o_full (w_q_full),
        .i_pop  (w_pop),
        .o_valid(w_job_valid),
        .o_data (w_job_out)
    );

    // banked neighbour reads, arithmetic and the output register
    vdg_back #(
        .MAX_SIZE_X (MAX_SIZE_X),
        .MAX_SIZE_Y (MAX_SIZE_Y),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_stride_y  (w_stride_y),
        .i_stride_z  (w_stride_z),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_divergence(w_div),
        .o_index     (w_index),
        .o_last      (o_m_tlast)
    );

    // pack divergence low, index above, pad to whole bytes
    assign o_m_tdata = {4'b0000, w_index, w_div};

endmodule

// ===== sim/volume_divergence_of_gradient_tb.sv =====
// volume_divergence_of_gradient_tb: self-checking bench for the 3d laplacian stream block
// drives voxel and flush transfers, predicts every divergence result and compares
// depends on vdg_pkg and volume_divergence_of_gradient
`timescale 1ns / 1ps

module volume_divergence_of_gradient_tb;
    import vdg_pkg::*;

    // one voxel or flush transfer waiting to go in
    typedef struct packed {
        logic        kind;
        logic [15:0] value;
    } t_voxel_req;

    // one divergence result as the block should send it
    typedef struct packed {
        logic [19:0] div;
        logic [23:0] idx;
        logic        last;
    } t_div_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     cfg_ready;

    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic        s_kind = 1'b0;
    logic        s_ready;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;
    logic        m_last;

    volume_divergence_of_gradient dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_kind),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .o_m_tlast   (m_last)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the block: sizes, absolute sample history and output position
    int unsigned dim_x = 128, dim_y = 128, dim_z = 1024;
    shortint     voxel_hist[longint];
    longint      samples_in;     // absolute count of stored samples
    longint      next_voxel_abs; // absolute sample index of the next voxel out
    longint      next_voxel_k;   // its raster index within the volume

    t_voxel_req  req_fifo[$];
    t_div_result div_expected[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count = 0;
    int n_samples = 0, n_flushes = 0, n_results = 0, n_phases = 0;

    // long receiver hold-off, owned by its own process
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    function automatic int unsigned clip_size(int unsigned v, int unsigned mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic longint voxel_at(longint a);
        return voxel_hist.exists(a) ? longint'(voxel_hist[a]) : 0;
    endfunction

    // first central difference at axis position u, seen from centre position c
    function automatic longint grad_at(longint ctr, longint u, longint c, longint n,
                                       longint stride);
        if (u < 1 || u + 1 >= n) return 0;
        return voxel_at(ctr + (u - 1 - c) * stride) - voxel_at(ctr + (u + 1 - c) * stride);
    endfunction

    function automatic longint axis_curv(longint ctr, longint c, longint n, longint stride);
        if (c < 1 || c + 1 >= n) return 0;
        return grad_at(ctr, c - 1, c, n, stride) - grad_at(ctr, c + 1, c, n, stride);
    endfunction

    // update the shadow for one accepted transfer, queue the divergence it releases
    task automatic predict_divergence(t_voxel_req r);
        longint sx, sy, sz, plane, vol, k, need, pend, sum;
        t_div_result e;
        sx = clip_size(dim_x, 128);
        sy = clip_size(dim_y, 128);
        sz = clip_size(dim_z, 1024);
        plane = sx * sy;
        vol = plane * sz;
        if (r.kind == REQ_SAMPLE) begin
            voxel_hist[samples_in] = shortint'(r.value);
            samples_in++;
            n_samples++;
        end else begin
            n_flushes++;
        end
        pend = samples_in - next_voxel_abs;
        if (pend == 0) return;
        k = next_voxel_k;
        need = k + 2 * plane;
        if (need > vol - 1) need = vol - 1;
        if (k + pend < need + 1) return;
        sum = axis_curv(next_voxel_abs, k % sx, sx, 1)
            + axis_curv(next_voxel_abs, (k / sx) % sy, sy, sx)
            + axis_curv(next_voxel_abs, k / plane, sz, plane);
        if (sum > 524287) sum = 524287;
        if (sum < -524288) sum = -524288;
        e.div = sum[19:0];
        e.idx = k[23:0];
        e.last = (k == vol - 1);
        div_expected.push_back(e);
        next_voxel_abs++;
        next_voxel_k = (k + 1 >= vol) ? 0 : k + 1;
    endtask

    // sender: holds a transfer until taken, idles at random between transfers
    bit         slot_full = 1'b0;
    t_voxel_req slot_req;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                predict_divergence(slot_req);
                slot_full = 1'b0;
            end
            if (!slot_full && req_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                slot_req = req_fifo.pop_front();
                slot_full = 1'b1;
            end
            s_valid <= slot_full;
            s_data  <= slot_req.value;
            s_kind  <= slot_req.kind;
        end
    end

    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver readiness and result checking
    always @(posedge i_clk) begin
        t_div_result exp_r;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (div_expected.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: div %0d idx %0d last %0b",
                                 $signed(m_data[19:0]), m_data[43:20], m_last);
                end else begin
                    exp_r = div_expected.pop_front();
                    if (m_data[19:0] !== exp_r.div || m_data[43:20] !== exp_r.idx
                            || m_last !== exp_r.last) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch: expected div %0d idx %0d last %0b, ",
                                      "got div %0d idx %0d last %0b"},
                                     $signed(exp_r.div), exp_r.idx, exp_r.last,
                                     $signed(m_data[19:0]), m_data[43:20], m_last);
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        // register taken at this edge: the stream restarts
        case (idx)
            REG_SIZE_X: dim_x = val & 8'hFF;
            REG_SIZE_Y: dim_y = val & 8'hFF;
            default:    dim_z = val & 11'h7FF;
        endcase
        next_voxel_abs = samples_in;
        next_voxel_k = 0;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic push_req(logic kind, logic [15:0] val);
        t_voxel_req r;
        r.kind = kind;
        r.value = val;
        req_fifo.push_back(r);
    endtask

    // whole volumes with random content, some stray flushes, then a drain of flushes or a cut-short volume
    task automatic queue_volumes(int nvol, int noise_pct);
        int unsigned plane, vol, cut, tail;
        plane = clip_size(dim_x, 128) * clip_size(dim_y, 128);
        vol = plane * clip_size(dim_z, 1024);
        for (int v = 0; v < nvol; v++)
            for (int unsigned i = 0; i < vol; i++) begin
                if ($urandom_range(99) < noise_pct) push_req(REQ_FLUSH, 16'($urandom()));
                push_req(REQ_SAMPLE, pick_sample());
            end
        // a volume may be cut short now and then, the next write drops its tail
        if ($urandom_range(99) < noise_pct) begin
            cut = $urandom_range(vol);
            for (int unsigned i = 0; i < cut; i++)
                push_req(REQ_SAMPLE, pick_sample());
        end else begin
            // enough flushes to release every voxel still waiting
            tail = (2 * plane + 1 < vol) ? 2 * plane + 1 : vol;
            for (int unsigned i = 0; i < tail; i++) push_req(REQ_FLUSH, '0);
        end
    endtask

    // wait for every transfer and result, then the pipeline tail
    task automatic drain_phase();
        while (req_fifo.size() > 0 || slot_full || s_valid || div_expected.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        n_phases++;
    endtask

    task automatic set_sizes(int unsigned sx, int unsigned sy, int unsigned sz);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed: 3x3x3 cube with full-scale extremes, flush with nothing ready first
        set_sizes(3, 3, 3);
        push_req(REQ_FLUSH, 16'hFFFF);
        for (int i = 0; i < 27; i++)
            push_req(REQ_SAMPLE, (i % 2 == 0) ? 16'h7FFF : 16'h8000);
        for (int i = 0; i < 20; i++) push_req(REQ_FLUSH, '0);
        drain_phase();

        // size extremes: zero acts as one, out-of-range acts as the maximum
        set_sizes(0, 0, 0);
        queue_volumes(3, 0);
        drain_phase();
        set_sizes(255, 1, 1);
        queue_volumes(1, 0);
        drain_phase();

        // random part, three idling modes in turn
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 72 : 0;
            recv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 30 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                set_sizes($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 4));
                if (mode == 2 && ph == 0) hold_arm = 1'b1; // block fills and stalls input
                queue_volumes($urandom_range(1, 2), 8);
                drain_phase();
            end
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        $display("covered %0d phases: %0d samples, %0d flushes, %0d results checked",
                 n_phases, n_samples, n_flushes, n_results);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", err_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("timeout with %0d results still expected", div_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
